FILE: rtl/asni_pkg.sv
// ----------------------------------------------------------------------------
// asni_pkg
// Shared constants and types for the ADC sample noise injector.
// ----------------------------------------------------------------------------
package asni_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int WORD_BITS       = 16;
    localparam int CFG_DATA_BITS   = 32;
    localparam int GAIN_BITS       = 8;

    // generator
    localparam int          STATE_BITS    = 32;
    localparam logic [31:0] FALLBACK_SEED = 32'h9E37_79B9;
    localparam int          XS_SHIFT_A    = 13;
    localparam int          XS_SHIFT_B    = 17;
    localparam int          XS_SHIFT_C    = 5;

    // noise shaping
    localparam int BYTE_SUM_BITS = 10;
    localparam int CENTRED_BITS  = 11;
    localparam int NOISE_CENTER  = 510;
    localparam int GAIN_FACTOR   = 7;
    localparam int GAIN_X7_BITS  = 11;
    localparam int NOISE_SHIFT   = 10;

    localparam logic [GAIN_X7_BITS-1:0] GAIN_X7_RESET = GAIN_X7_BITS'(8 * GAIN_FACTOR);

    // register map
    typedef enum logic [0:0] {
        REG_NOISE_GAIN = 1'b0,
        REG_NOISE_SEED = 1'b1
    } reg_idx_t;

    // generator control
    typedef struct packed {
        logic                  load;
        logic                  advance;
        logic [STATE_BITS-1:0] seed;
    } gen_ctrl_t;

endpackage

FILE: rtl/asni_gen.sv
// ----------------------------------------------------------------------------
// asni_gen
// Xorshift32 generator state and the centred byte sum of its next value.
// ----------------------------------------------------------------------------
module asni_gen (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  asni_pkg::gen_ctrl_t                      ctrl,
    output logic signed [asni_pkg::CENTRED_BITS-1:0] centred
);

    logic [asni_pkg::STATE_BITS-1:0]    state_reg;
    logic [asni_pkg::STATE_BITS-1:0]    state_next;
    logic [asni_pkg::STATE_BITS-1:0]    xs_a;
    logic [asni_pkg::STATE_BITS-1:0]    xs_b;
    logic [asni_pkg::STATE_BITS-1:0]    xs_c;
    logic [asni_pkg::BYTE_SUM_BITS-1:0] byte_sum;

    assign xs_a = state_reg ^ (state_reg << asni_pkg::XS_SHIFT_A);
    assign xs_b = xs_a ^ (xs_a >> asni_pkg::XS_SHIFT_B);
    assign xs_c = xs_b ^ (xs_b << asni_pkg::XS_SHIFT_C);

    assign byte_sum = asni_pkg::BYTE_SUM_BITS'(xs_c[31:24])
                    + asni_pkg::BYTE_SUM_BITS'(xs_c[23:16])
                    + asni_pkg::BYTE_SUM_BITS'(xs_c[15:8])
                    + asni_pkg::BYTE_SUM_BITS'(xs_c[7:0]);

    assign centred = $signed({1'b0, byte_sum})
                   - $signed(asni_pkg::CENTRED_BITS'(asni_pkg::NOISE_CENTER));

    always_comb
    begin
        state_next = state_reg;
        if (ctrl.load)
        begin
            // a zero seed would lock the generator
            state_next = (ctrl.seed != '0) ? ctrl.seed : asni_pkg::FALLBACK_SEED;
        end
        else if (ctrl.advance)
        begin
            state_next = xs_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asni_pkg::FALLBACK_SEED;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/asni_scale.sv
// ----------------------------------------------------------------------------
// asni_scale
// Scales the centred noise by gain*7, floors by 2^10, adds and saturates; an inactive word passes unchanged.
// ----------------------------------------------------------------------------
module asni_scale #(
    parameter int SAMPLE_BITS = asni_pkg::SAMPLE_BITS_DEF
) (
    input  logic [asni_pkg::WORD_BITS-1:0]           raw,
    input  logic                                     active,
    input  logic signed [asni_pkg::CENTRED_BITS-1:0] centred,
    input  logic [asni_pkg::GAIN_X7_BITS-1:0]        gain_x7,
    output logic [asni_pkg::WORD_BITS-1:0]           noisy
);

    localparam int PROD_W  = asni_pkg::CENTRED_BITS + asni_pkg::GAIN_X7_BITS + 1;
    localparam int NOISE_W = PROD_W - asni_pkg::NOISE_SHIFT;
    localparam int SUM_W   = ((SAMPLE_BITS > NOISE_W) ? SAMPLE_BITS : NOISE_W) + 2;
    localparam logic signed [SUM_W-1:0] CODE_MAX = SUM_W'((1 << SAMPLE_BITS) - 1);

    logic signed [asni_pkg::GAIN_X7_BITS:0] gain_s;
    logic signed [PROD_W-1:0]               product;
    logic signed [NOISE_W-1:0]              noise;
    logic signed [SUM_W-1:0]                code_s;
    logic signed [SUM_W-1:0]                sum;
    logic [SAMPLE_BITS-1:0]                 code_sat;

    assign gain_s  = $signed({1'b0, gain_x7});
    assign product = PROD_W'(centred) * PROD_W'(gain_s);
    // dropping the low bits of a two's complement value is a floor
    assign noise   = product[PROD_W-1:asni_pkg::NOISE_SHIFT];
    assign code_s  = $signed(SUM_W'(raw[SAMPLE_BITS-1:0]));
    assign sum     = code_s + SUM_W'(noise);

    always_comb
    begin
        if (sum < 0)
        begin
            code_sat = '0;
        end
        else if (sum > CODE_MAX)
        begin
            code_sat = '1;
        end
        else
        begin
            code_sat = sum[SAMPLE_BITS-1:0];
        end
    end

    assign noisy = active ? {raw[asni_pkg::WORD_BITS-1:SAMPLE_BITS], code_sat} : raw;

endmodule

FILE: rtl/adc_sample_noise_injector_top.sv
// ----------------------------------------------------------------------------
// adc_sample_noise_injector_top
// Adds xorshift32-based near-Gaussian noise to a stream of tagged ADC words.
// ----------------------------------------------------------------------------
// One word is taken per clock while the output does not stall. An input
// stage captures the word together with the centred byte sum of the
// freshly advanced generator, and the result register holds the scaled,
// saturated sum. The generator can advance for every accepted word, so
// it does not limit the rate. With noise_gain at zero a word passes
// unchanged and the generator holds. Writing noise_seed reloads the
// generator (a zero seed loads the fallback value); the user must write
// configuration only while the stream is idle, the block does not enforce it.
module adc_sample_noise_injector_top #(
    parameter int SAMPLE_BITS = asni_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [asni_pkg::WORD_BITS-1:0]        s_axis_tdata,  // [15:0] raw_sample
    input  logic                                  s_axis_tlast,  // last_in
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [asni_pkg::WORD_BITS-1:0]        m_axis_tdata,  // [15:0] noisy_sample
    output logic                                  m_axis_tlast,  // last_out
    // configuration
    input  logic                                  cfg_we,
    input  asni_pkg::reg_idx_t                    cfg_idx,
    input  logic [asni_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    logic [asni_pkg::GAIN_X7_BITS-1:0] gain_x7_reg;
    logic [asni_pkg::GAIN_X7_BITS-1:0] gain_x7_next;
    logic [asni_pkg::GAIN_BITS-1:0]    gain_wr;

    logic                                     s1_vld_reg;
    logic [asni_pkg::WORD_BITS-1:0]           s1_raw_reg;
    logic                                     s1_last_reg;
    logic                                     s1_active_reg;
    logic signed [asni_pkg::CENTRED_BITS-1:0] s1_centred_reg;

    logic                           out_vld_reg;
    logic [asni_pkg::WORD_BITS-1:0] out_data_reg;
    logic                           out_last_reg;

    logic                                     out_ready;
    logic                                     in_take;
    logic                                     gain_on;
    asni_pkg::gen_ctrl_t                      gen_ctrl;
    logic signed [asni_pkg::CENTRED_BITS-1:0] gen_centred;
    logic [asni_pkg::WORD_BITS-1:0]           noisy;

    assign out_ready     = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = !s1_vld_reg || out_ready;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign gain_on       = (gain_x7_reg != '0);

    // gain*7 = gain*8 - gain
    assign gain_wr      = cfg_wdata[asni_pkg::GAIN_BITS-1:0];
    assign gain_x7_next = {gain_wr, 3'b000} - asni_pkg::GAIN_X7_BITS'(gain_wr);

    always_comb
    begin
        gen_ctrl.load    = 1'b0;
        gen_ctrl.advance = in_take && gain_on;
        gen_ctrl.seed    = cfg_wdata;
        if (cfg_we)
        begin
            case (cfg_idx)
                asni_pkg::REG_NOISE_SEED: gen_ctrl.load = 1'b1;
                default:                  gen_ctrl.load = 1'b0;
            endcase
        end
    end

    asni_gen u_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (gen_ctrl),
        .centred (gen_centred)
    );

    asni_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .raw     (s1_raw_reg),
        .active  (s1_active_reg),
        .centred (s1_centred_reg),
        .gain_x7 (gain_x7_reg),
        .noisy   (noisy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_x7_reg <= asni_pkg::GAIN_X7_RESET;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_idx == asni_pkg::REG_NOISE_GAIN))
            begin
                gain_x7_reg <= gain_x7_next;
            end
            if (s_axis_tready)
            begin
                s1_vld_reg <= s_axis_tvalid;
            end
            if (out_ready)
            begin
                out_vld_reg <= s1_vld_reg;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_raw_reg     <= s_axis_tdata;
            s1_last_reg    <= s_axis_tlast;
            s1_active_reg  <= gain_on;
            s1_centred_reg <= gen_centred;
        end
        if (out_ready && s1_vld_reg)
        begin
            out_data_reg <= noisy;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // a word with noise disabled reaches the output unchanged
    a_bypass_exact : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && !s1_active_reg && out_ready)
        |=> (out_data_reg == $past(s1_raw_reg)))
        else $error("bypassed word altered");

    // the channel tag is never touched
    a_tag_kept : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && out_ready)
        |=> (out_data_reg[asni_pkg::WORD_BITS-1:SAMPLE_BITS]
             == $past(s1_raw_reg[asni_pkg::WORD_BITS-1:SAMPLE_BITS])))
        else $error("channel tag changed");

    // a word held in the input stage is not dropped while the output stalls
    a_stage_held : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && !out_ready) |=> (s1_vld_reg && $stable(s1_raw_reg)))
        else $error("input stage lost a word");

endmodule

FILE: bench/adc_sample_noise_injector_top_tb.sv
// ----------------------------------------------------------------------------
// adc_sample_noise_injector_top_tb
// Self-checking bench for the ADC sample noise injector. A behavioural
// predictor runs the xorshift32 generator and the noise shaping alongside
// the block. Every accepted output word is checked against the oldest
// predicted word. Directed cases cover the reset defaults, gain zero,
// saturation at both ends, masking of wide register writes and the zero
// seed. Random phases follow, each with its own gain and seed, some with
// bursty input traffic and some with patterned output back-pressure.
// ----------------------------------------------------------------------------
module adc_sample_noise_injector_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_BITS = asni_pkg::SAMPLE_BITS_DEF;
    localparam logic [asni_pkg::WORD_BITS-1:0] CODE_MAX =
        asni_pkg::WORD_BITS'((1 << CODE_BITS) - 1);
    localparam int DRAIN_CYCLES = 8;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_WORDS  = 125;

    typedef struct packed {
        logic [asni_pkg::WORD_BITS-1:0] word;
        logic                           last;
    } noisy_word_t;

    logic                               clk           = 1'b0;
    logic                               rst_n         = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [asni_pkg::WORD_BITS-1:0]     s_axis_tdata  = '0;
    logic                               s_axis_tlast  = 1'b0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [asni_pkg::WORD_BITS-1:0]     m_axis_tdata;
    logic                               m_axis_tlast;
    logic                               cfg_we        = 1'b0;
    asni_pkg::reg_idx_t                 cfg_idx       = asni_pkg::REG_NOISE_GAIN;
    logic [asni_pkg::CFG_DATA_BITS-1:0] cfg_wdata     = '0;

    // predictor state, mirrors the block after reset
    logic [asni_pkg::GAIN_BITS-1:0]  model_gain  = asni_pkg::GAIN_BITS'(8);
    logic [asni_pkg::STATE_BITS-1:0] model_state = asni_pkg::FALLBACK_SEED;

    noisy_word_t expected_words[$];
    int          err_cnt      = 0;
    int          burst_left   = 0;
    bit          gaps_on      = 1'b0;
    bit          stall_on     = 1'b0;
    int unsigned stall_period = 4;
    int unsigned stall_len    = 0;
    int unsigned cyc          = 0;

    adc_sample_noise_injector_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata)
    );

    always #10 clk = ~clk;

    // receiver back-pressure: low at the start of each period, while cyc modulo stall_period is below stall_len
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        m_axis_tready <= !(stall_on && ((cyc % stall_period) < stall_len));
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_error(input string what, input logic [31:0] exp_v,
                                input logic [31:0] got_v);
        $display("mismatch %s at %0t: expected %h got %h", what, $realtime, exp_v, got_v);
        err_cnt++;
    endtask

    // advances the generator unless gain is zero, then adds the shaped noise
    function automatic logic [asni_pkg::WORD_BITS-1:0] noisy_word(
        input logic [asni_pkg::WORD_BITS-1:0] raw);
        logic [asni_pkg::STATE_BITS-1:0] s;
        int                              centred;
        int                              offset;
        int                              code;
        if (model_gain == 0)
            return raw;
        s = model_state;
        s ^= s << asni_pkg::XS_SHIFT_A;
        s ^= s >> asni_pkg::XS_SHIFT_B;
        s ^= s << asni_pkg::XS_SHIFT_C;
        model_state = s;
        centred = int'(s[31:24]) + int'(s[23:16]) + int'(s[15:8]) + int'(s[7:0])
                  - asni_pkg::NOISE_CENTER;
        // arithmetic shift of a signed int rounds towards minus infinity
        offset = (centred * (int'(model_gain) * asni_pkg::GAIN_FACTOR))
                 >>> asni_pkg::NOISE_SHIFT;
        code = int'(raw & CODE_MAX) + offset;
        if (code < 0)
            code = 0;
        if (code > int'(CODE_MAX))
            code = int'(CODE_MAX);
        return (raw & ~CODE_MAX) | asni_pkg::WORD_BITS'(code);
    endfunction

    task automatic send_word(input logic [asni_pkg::WORD_BITS-1:0] word, input logic last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_words.push_back('{word: noisy_word(word), last: last});
        burst_left--;
    endtask

    task automatic wait_idle();
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_words.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input asni_pkg::reg_idx_t idx,
                             input logic [asni_pkg::CFG_DATA_BITS-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == asni_pkg::REG_NOISE_GAIN)
            model_gain = value[asni_pkg::GAIN_BITS-1:0];
        else
            model_state = (value != 0) ? value : asni_pkg::FALLBACK_SEED;
        @(posedge clk);
    endtask

    function automatic logic [asni_pkg::WORD_BITS-1:0] random_word();
        logic [asni_pkg::WORD_BITS-1:0] code;
        case ($urandom_range(0, 5))
            0:       code = '0;
            1:       code = CODE_MAX;
            2:       code = asni_pkg::WORD_BITS'($urandom_range(0, 15));
            3:       code = CODE_MAX - asni_pkg::WORD_BITS'($urandom_range(0, 15));
            default: code = asni_pkg::WORD_BITS'($urandom()) & CODE_MAX;
        endcase
        return (asni_pkg::WORD_BITS'($urandom()) & ~CODE_MAX) | code;
    endfunction

    // reset gain and the fallback generator state, no register written yet
    task automatic test_defaults();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        send_word(16'h0000, 1'b0);
        send_word(16'h0FFF, 1'b0);
        send_word(16'hF000, 1'b0);
        send_word(16'h0800, 1'b1);
        send_word(16'hFFFF, 1'b1);
    endtask

    task automatic test_gain_and_seed();
        gaps_on      = 1'b1;
        stall_on     = 1'b1;
        stall_period = 3;
        stall_len    = 1;
        // gain zero passes words untouched and holds the generator
        write_reg(asni_pkg::REG_NOISE_GAIN, 32'h0000_0000);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b1);
        send_word(16'h7ABC, 1'b0);
        // strongest noise drives both ends into saturation
        write_reg(asni_pkg::REG_NOISE_GAIN, 32'h0000_00FF);
        write_reg(asni_pkg::REG_NOISE_SEED, 32'hFFFF_FFFF);
        send_word(16'h0000, 1'b0);
        send_word(16'h0FFF, 1'b0);
        send_word(16'hF000, 1'b1);
        send_word(16'hFFFF, 1'b0);
        // bits above the gain width are dropped
        write_reg(asni_pkg::REG_NOISE_GAIN, 32'hFFFF_FF01);
        send_word(16'h0800, 1'b0);
        send_word(16'h3001, 1'b1);
        // zero seed falls back to the fixed seed
        write_reg(asni_pkg::REG_NOISE_SEED, 32'h0000_0000);
        send_word(16'h0800, 1'b0);
        send_word(16'hA800, 1'b1);
    endtask

    task automatic test_random_phases();
        logic [asni_pkg::CFG_DATA_BITS-1:0] gain;
        logic [asni_pkg::CFG_DATA_BITS-1:0] seed;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                1:       gain = 32'h0000_00FF;
                2:       gain = 32'h0000_0000;
                3:       gain = 32'h0000_0001;
                6:       gain = 32'h0000_0080;
                default: gain = $urandom_range(1, 255);
            endcase
            case (p)
                0:       seed = 32'h0000_0000;
                1:       seed = 32'hFFFF_FFFF;
                default: seed = $urandom();
            endcase
            write_reg(asni_pkg::REG_NOISE_GAIN, gain);
            write_reg(asni_pkg::REG_NOISE_SEED, seed);
            gaps_on      = (p % 2) == 1;
            stall_on     = (p % 3) != 0;
            stall_period = $urandom_range(2, 9);
            stall_len    = $urandom_range(1, stall_period - 1);
            for (int i = 0; i < PHASE_WORDS; i++)
                send_word(random_word(), $urandom_range(0, 7) == 0);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        noisy_word_t exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
                report_error("unexpected transaction", 32'h0, 32'(m_axis_tdata));
            else
            begin
                exp_w = expected_words.pop_front();
                if (m_axis_tdata !== exp_w.word)
                    report_error("noisy_sample", 32'(exp_w.word), 32'(m_axis_tdata));
                if (m_axis_tlast !== exp_w.last)
                    report_error("last_out", 32'(exp_w.last), 32'(m_axis_tlast));
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_gain_and_seed();
        test_random_phases();
        wait_idle();
        if (expected_words.size() != 0)
            report_error("results still outstanding", 32'(expected_words.size()), 32'h0);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
